>>> hdl/crc16_block_validator_defines.svh
// assertion macros for the crc16 block validator
`ifndef CRC16_BLOCK_VALIDATOR_DEFINES_SVH
`define CRC16_BLOCK_VALIDATOR_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define CBV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/cbv_pkg.sv
// shared types, constants and the bytewise crc update for the block validator
package cbv_pkg;

  localparam int DATA_W    = 8;
  localparam int CRC_W     = 16;
  localparam int M_TDATA_W = 40;

  localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } item_t;

  // position within a block: stored crc low byte, high byte, then hashed body
  typedef enum logic [1:0] {
    POS_LOW  = 2'd0,
    POS_HIGH = 2'd1,
    POS_BODY = 2'd2
  } pos_t;

  // ccitt-false bytewise shift-xor update
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] v0;
    logic [CRC_W-1:0] v1;
    logic [CRC_W-1:0] v2;
    logic [CRC_W-1:0] v3;
    v0 = {crc[7:0], crc[15:8]} ^ {8'h00, b};
    v1 = v0 ^ {12'h000, v0[7:4]};
    v2 = v1 ^ {v1[3:0], 12'h000};
    v3 = v2 ^ {3'b000, v2[7:0], 5'b00000};
    return v3;
  endfunction

endpackage

>>> hdl/crc16_block_validator.sv
// top level of the crc16 block validator
//
// checks a stored info block against its crc-16/ccitt-false (poly 0x1021,
// seed 0xffff, not reflected). bytes come in on the slave stream one item
// per byte, memory order, with s_tlast on the final byte of the block.
// the first two bytes are the stored crc, low byte first; they are captured,
// not hashed. every later byte goes through the bytewise crc update.
// on the last byte one result item leaves on the master stream:
// computed crc, stored crc and a match flag; the block then rearms.
// a block of one or two bytes is reported with its partial state.
// path: a byte is registered in the input register; on a last byte the
// result is registered in turn and shown on m_tvalid.
// throughput: one byte per cycle unless a held result stalls a last byte,
// with a combinational xor network between input and state/result registers.
// stalls: a held result only blocks a last byte; body bytes keep flowing,
// and the input register absorbs one more item while the output waits.
// reset (rst, synchronous, active high) drops both valids and restores the
// seed, a zero stored crc and the start-of-block position.
module crc16_block_validator
  import cbv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [15:0] computed_crc, [31:16] stored_crc,
                                 // [32] crc_matches, [39:33] zero
);

`include "crc16_block_validator_defines.svh"

  // handshake between input register and core
  logic  in_valid;
  logic  advance;
  item_t staged;

  cbv_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .in_valid (in_valid),
    .staged   (staged)
  );

  cbv_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .staged   (staged),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // body bytes must never wait on the output side
  `CBV_ASSERT_NOW(a_body_flows, in_valid && !staged.last_byte, advance, "body byte stalled")
  // the match flag agrees with the two crcs it reports
  `CBV_ASSERT_NOW(a_match_flag, m_tvalid, m_tdata[32] == (m_tdata[15:0] == m_tdata[31:16]), "match flag wrong")
  // a last byte taken by the core shows up as a result next cycle
  `CBV_ASSERT_NEXT(a_last_emits, in_valid && advance && staged.last_byte, m_tvalid, "result missing")

endmodule

>>> hdl/cbv_in_stage.sv
// input register stage: holds one accepted item until the core takes it
module cbv_in_stage
  import cbv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // last_byte
  input  logic        advance,
  output logic        in_valid,
  output item_t       staged
);

  logic in_valid_next;

  assign s_tready = !in_valid || advance;

  always_comb begin
    in_valid_next = in_valid;
    if (s_tvalid && s_tready) begin
      in_valid_next = 1'b1;
    end else if (advance) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      staged.data_byte <= s_tdata;
      staged.last_byte <= s_tlast;
    end
  end

endmodule

>>> hdl/cbv_core.sv
// block state, crc update and the result register
module cbv_core
  import cbv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  item_t                staged,
  output logic                 advance,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  pos_t             pos;
  pos_t             pos_next;
  logic [CRC_W-1:0] running_crc;
  logic [CRC_W-1:0] running_crc_next;
  logic [CRC_W-1:0] captured_crc;
  logic [CRC_W-1:0] captured_crc_next;
  logic             m_tvalid_next;
  logic             take;
  logic             emit;

  // a non-last item never needs the result slot
  assign advance = !staged.last_byte || !m_tvalid || m_tready;
  assign take    = in_valid && advance;
  assign emit    = take && staged.last_byte;

  always_comb begin
    pos_next = pos;
    if (take) begin
      if (staged.last_byte) begin
        pos_next = POS_LOW;
      end else begin
        case (pos)
          POS_LOW:  pos_next = POS_HIGH;
          POS_HIGH: pos_next = POS_BODY;
          POS_BODY: pos_next = POS_BODY;
          default:  pos_next = POS_LOW;
        endcase
      end
    end
  end

  // state after this byte, before any rearm
  always_comb begin
    running_crc_next  = running_crc;
    captured_crc_next = captured_crc;
    case (pos)
      POS_LOW:  captured_crc_next = {captured_crc[15:8], staged.data_byte};
      POS_HIGH: captured_crc_next = {staged.data_byte, captured_crc[7:0]};
      POS_BODY: running_crc_next  = crc_step(running_crc, staged.data_byte);
      default:  running_crc_next  = running_crc;
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid && !m_tready;
    if (emit) begin
      m_tvalid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= POS_LOW;
      running_crc  <= CRC_SEED;
      captured_crc <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      pos      <= pos_next;
      m_tvalid <= m_tvalid_next;
      if (emit) begin
        running_crc  <= CRC_SEED;
        captured_crc <= '0;
      end else if (take) begin
        running_crc  <= running_crc_next;
        captured_crc <= captured_crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {7'b0000000, (running_crc_next == captured_crc_next),
                  captured_crc_next, running_crc_next};
    end
  end

endmodule

>>> tb/tb_crc16_block_validator.sv
// self-checking testbench for the crc16 block validator
`timescale 1ns / 1ps

module tb_crc16_block_validator
  import cbv_pkg::*;
();

  localparam logic [15:0] CCITT_POLY = 16'h1021;
  localparam logic [15:0] CCITT_SEED = 16'hFFFF;
  localparam int          BYTE_TARGET = 1500;
  localparam int          IDLE_PCT = 36;
  // window of accepted bytes where neither side idles
  localparam int          CALM_FROM = 600;
  localparam int          CALM_TO = 850;
  localparam int          DRAIN_CYCLES = 12;

  typedef logic [7:0] byte_list_t[$];

  // one byte of an info block as it goes out on the slave stream
  typedef struct {
    logic [7:0] data;
    logic       last;
  } block_byte_t;

  // one check report as it should leave on the master stream
  typedef struct {
    logic [15:0] computed;
    logic [15:0] stored;
    logic        is_match;
  } crc_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tlast = 1'b0;    // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [15:0] computed_crc, [31:16] stored_crc,
                                  // [32] crc_matches, [39:33] zero

  block_byte_t byte_feed[$];      // bytes still to be offered
  crc_report_t reports_due[$];    // reports predicted but not yet seen

  // predictor state, mirrors what the block holds between bytes
  logic [15:0] body_crc;
  logic [15:0] header_crc;
  pos_t        block_pos;

  int bytes_accepted = 0;
  int reports_checked = 0;
  int good_blocks_seen = 0;
  int short_blocks_sent = 0;
  int blocks_sent = 0;
  int failures = 0;
  logic calm;

  assign calm = (bytes_accepted >= CALM_FROM) && (bytes_accepted < CALM_TO);

  crc16_block_validator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ccitt-false, msb first, one bit per pass
  function automatic logic [15:0] ccitt_update(input logic [15:0] acc,
                                               input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ CCITT_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [15:0] ccitt_over(input byte_list_t body);
    logic [15:0] acc;
    acc = CCITT_SEED;
    foreach (body[i]) acc = ccitt_update(acc, body[i]);
    return acc;
  endfunction

  // queue a whole block, flagging its final byte
  task automatic queue_block(input byte_list_t blk);
    block_byte_t bb;
    foreach (blk[i]) begin
      bb.data = blk[i];
      bb.last = (i == blk.size() - 1);
      byte_feed.push_back(bb);
    end
    blocks_sent++;
    if (blk.size() < 3) short_blocks_sent++;
  endtask

  // header is either the true crc of the body or whatever the caller gives
  task automatic queue_body(input byte_list_t body, input bit good,
                            input logic [15:0] bad_header);
    byte_list_t blk;
    logic [15:0] hdr;
    hdr = good ? ccitt_over(body) : bad_header;
    blk.push_back(hdr[7:0]);
    blk.push_back(hdr[15:8]);
    foreach (body[i]) blk.push_back(body[i]);
    queue_block(blk);
  endtask

  // block-level predictor: header bytes captured, body bytes hashed,
  // last byte closes the block with a report and rearms
  task automatic fold_block_byte(input logic [7:0] b, input logic last);
    crc_report_t rep;
    case (block_pos)
      POS_LOW: begin
        header_crc[7:0] = b;
        block_pos = POS_HIGH;
      end
      POS_HIGH: begin
        header_crc[15:8] = b;
        block_pos = POS_BODY;
      end
      default: begin
        body_crc = ccitt_update(body_crc, b);
      end
    endcase
    if (last) begin
      rep.computed = body_crc;
      rep.stored = header_crc;
      rep.is_match = (body_crc == header_crc);
      reports_due.push_back(rep);
      body_crc = CCITT_SEED;
      header_crc = '0;
      block_pos = POS_LOW;
    end
  endtask

  // directed blocks, then random ones until the byte target is met
  task automatic build_stimulus();
    byte_list_t body;
    byte_list_t blk;
    int len;
    int roll;
    // one-byte blocks: stored crc is that byte alone, computed stays seed
    blk = {8'h00};
    queue_block(blk);
    blk = {8'hFF};
    queue_block(blk);
    // two-byte blocks: ff ff happens to match the untouched seed
    blk = {8'hFF, 8'hFF};
    queue_block(blk);
    blk = {8'h00, 8'h00};
    queue_block(blk);
    // shortest blocks with a body, extreme body values
    body = {8'h00};
    queue_body(body, 1'b1, 16'h0000);
    body = {8'hFF};
    queue_body(body, 1'b1, 16'h0000);
    body = {8'hAB};
    queue_body(body, 1'b0, 16'h1234);
    // standard check string "123456789", crc 0x29b1
    body = {8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    queue_body(body, 1'b1, 16'h0000);

    while (byte_feed.size() < BYTE_TARGET) begin
      roll = $urandom_range(99);
      // mostly short blocks, a few long ones
      if (roll < 8) len = $urandom_range(2, 1);
      else if (roll < 75) len = $urandom_range(14, 3);
      else if (roll < 95) len = $urandom_range(40, 15);
      else len = $urandom_range(120, 41);
      if (len < 3) begin
        blk.delete();
        for (int i = 0; i < len; i++) blk.push_back(8'($urandom_range(255)));
        queue_block(blk);
      end else begin
        body.delete();
        for (int i = 0; i < len - 2; i++) body.push_back(8'($urandom_range(255)));
        // most blocks carry a correct header, the rest a random one
        queue_body(body, $urandom_range(99) < 60, 16'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  // slave-side driver: offers the next byte once the previous one is taken
  always @(posedge clk) begin : byte_driver
    block_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (byte_feed.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = byte_feed.pop_front();
        s_tdata <= nxt.data;
        s_tlast <= nxt.last;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // master-side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: checks reports in order, feeds accepted bytes to the predictor
  always @(posedge clk) begin : report_monitor
    crc_report_t want;
    if (rst) begin
      body_crc = CCITT_SEED;
      header_crc = '0;
      block_pos = POS_LOW;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reports_due.size() == 0) begin
          $error("unexpected report: m_tdata=%h", m_tdata);
          failures++;
        end else begin
          want = reports_due.pop_front();
          reports_checked++;
          if (m_tdata[32]) good_blocks_seen++;
          if (m_tdata[15:0] !== want.computed) begin
            $error("computed_crc: expected %h, actual %h", want.computed, m_tdata[15:0]);
            failures++;
          end
          if (m_tdata[31:16] !== want.stored) begin
            $error("stored_crc: expected %h, actual %h", want.stored, m_tdata[31:16]);
            failures++;
          end
          if (m_tdata[32] !== want.is_match) begin
            $error("crc_matches: expected %b, actual %b", want.is_match, m_tdata[32]);
            failures++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        fold_block_byte(s_tdata, s_tlast);
        bytes_accepted++;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // all bytes handed over, then all reports back, then a quiet tail
    while (byte_feed.size() > 0 || s_tvalid) @(posedge clk);
    while (reports_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d bytes in %0d blocks (%0d short), %0d reports checked, %0d valid",
             bytes_accepted, blocks_sent, short_blocks_sent, reports_checked,
             good_blocks_seen);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> crc16_block_validator.f
+incdir+hdl
hdl/cbv_pkg.sv
hdl/cbv_in_stage.sv
hdl/cbv_core.sv
hdl/crc16_block_validator.sv
tb/tb_crc16_block_validator.sv
